/* rtl/core/esd_pkg.sv */
// Package for the escape sequence decoder: character codes, decode modes,
// the burst word passed from the front end to the back end, queue sizing.
// No dependencies.
package esd_pkg;

  // Character codes
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharNul    = 8'h00;

  // Largest number of result words one input word can cause
  localparam int unsigned BurstMax = 4;
  localparam int unsigned BurstIdxW = $clog2(BurstMax);
  localparam int unsigned BurstCntW = $clog2(BurstMax + 1);

  // Queue between front end and back end
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Decode mode
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX0  = 2'd2,
    MODE_HEX1  = 2'd3
  } mode_e;

  // One burst of result words caused by one input word
  typedef struct packed {
    logic [BurstMax-1:0][7:0] data;     // result bytes, slot 0 first
    logic [BurstIdxW-1:0]     last_idx; // slot of the final result
    logic                     term;     // final result is the terminator
  } burst_t;

endpackage

/* rtl/core/esd_front.sv */
// Front end of the escape sequence decoder: accepts text words, tracks the
// escape state and turns each word into a burst of zero to four results.
// Depends on esd_pkg.
module esd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_text_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output esd_pkg::burst_t q_burst_o
);
  import esd_pkg::*;

  mode_e                mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic [BurstCntW-1:0] cnt;
  logic                 accept;
  logic                 b_hex, held_hex;
  logic [8:0]           esc;

  // Hex digit check
  function automatic logic is_hex(input logic [7:0] b);
    logic dig, low, up;
    dig = (b >= 8'h30) && (b <= 8'h39);
    low = (b >= 8'h61) && (b <= 8'h66);
    up  = (b >= 8'h41) && (b <= 8'h46);
    return dig || low || up;
  endfunction

  // Hex digit value, valid only for hex digits
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic dig;
    dig = (b >= 8'h30) && (b <= 8'h39);
    return dig ? b[3:0] : (b[3:0] + 4'd9);
  endfunction

  // Simple escapes: bit 8 flags a known escape, low byte is its value
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      8'h30:   r = {1'b1, 8'h00};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b_hex      = is_hex(in_byte_i);
  assign held_hex   = is_hex(held_q);
  assign esc        = esc_map(in_byte_i);

  // Classify the word and build its burst
  always_comb begin
    mode_d         = mode_q;
    held_d         = held_q;
    cnt            = '0;
    q_burst_o.data = '0;
    q_burst_o.term = 1'b0;
    if (end_of_text_i) begin
      mode_d         = MODE_PLAIN;
      held_d         = '0;
      q_burst_o.term = 1'b1;
      unique case (mode_q)
        MODE_PLAIN: begin
          cnt = BurstCntW'(1);
        end
        MODE_ESC: begin
          q_burst_o.data[0] = CharBslash;
          cnt               = BurstCntW'(2);
        end
        MODE_HEX0: begin
          q_burst_o.data[0] = CharBslash;
          q_burst_o.data[1] = CharX;
          cnt               = BurstCntW'(3);
        end
        MODE_HEX1: begin
          q_burst_o.data[0] = CharBslash;
          q_burst_o.data[1] = CharX;
          q_burst_o.data[2] = held_q;
          cnt               = BurstCntW'(4);
        end
        default: cnt = '0;
      endcase
    end else begin
      unique case (mode_q)
        MODE_PLAIN: begin
          if (in_byte_i == CharBslash) begin
            mode_d = MODE_ESC;
          end else begin
            q_burst_o.data[0] = in_byte_i;
            cnt               = BurstCntW'(1);
          end
        end
        MODE_ESC: begin
          mode_d = MODE_PLAIN;
          if (in_byte_i == CharX) begin
            mode_d = MODE_HEX0;
          end else if (esc[8]) begin
            q_burst_o.data[0] = esc[7:0];
            cnt               = BurstCntW'(1);
          end else begin
            q_burst_o.data[0] = CharBslash;
            q_burst_o.data[1] = in_byte_i;
            cnt               = BurstCntW'(2);
          end
        end
        MODE_HEX0: begin
          if (b_hex) begin
            held_d = in_byte_i;
            mode_d = MODE_HEX1;
          end else begin
            mode_d            = MODE_PLAIN;
            q_burst_o.data[0] = CharBslash;
            q_burst_o.data[1] = CharX;
            if (in_byte_i == CharBslash) begin
              mode_d = MODE_ESC;
              cnt    = BurstCntW'(2);
            end else begin
              q_burst_o.data[2] = in_byte_i;
              cnt               = BurstCntW'(3);
            end
          end
        end
        MODE_HEX1: begin
          mode_d = MODE_PLAIN;
          held_d = '0;
          if (b_hex && held_hex) begin
            q_burst_o.data[0] = {hex_nib(held_q), hex_nib(in_byte_i)};
            cnt               = BurstCntW'(1);
          end else begin
            q_burst_o.data[0] = CharBslash;
            q_burst_o.data[1] = CharX;
            q_burst_o.data[2] = held_q;
            if (in_byte_i == CharBslash) begin
              mode_d = MODE_ESC;
              cnt    = BurstCntW'(3);
            end else begin
              q_burst_o.data[3] = in_byte_i;
              cnt               = BurstCntW'(4);
            end
          end
        end
        default: mode_d = MODE_PLAIN;
      endcase
    end
    q_burst_o.last_idx = BurstIdxW'(cnt - BurstCntW'(1));
  end

  assign q_push_o = accept && (cnt != '0);

  // Hold decode state, advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

/* rtl/core/esd_queue.sv */
// Short register queue of bursts between the decoder front end and back end.
// Depends on esd_pkg.
module esd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  esd_pkg::burst_t burst_i,
  output logic            full_o,
  input  logic            pop_i,
  output esd_pkg::burst_t burst_o,
  output logic            valid_o
);
  import esd_pkg::*;

  burst_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign burst_o = mem_q[rd_ptr_q];

  // Advance a pointer with wrap at the queue depth
  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : (p + QueuePtrW'(1));
  endfunction

  // Store pushed bursts
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= burst_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

/* rtl/core/esd_back.sv */
// Back end of the escape sequence decoder: walks each queued burst and
// sends, while the output is ready, one result word per cycle from a register.
// Depends on esd_pkg.
module esd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  esd_pkg::burst_t q_burst_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            is_terminator_o,
  output logic            run_last_o
);
  import esd_pkg::*;

  logic [BurstIdxW-1:0] idx_q, idx_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q;
  logic                 term_q, last_q;
  logic                 load, at_last;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign at_last = (idx_q == q_burst_i.last_idx);
  assign q_pop_o = load && at_last;

  // Step through the burst, drop the output word once taken
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : (idx_q + BurstIdxW'(1));
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_burst_i.data[idx_q];
      term_q <= q_burst_i.term && at_last;
      last_q <= at_last;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign is_terminator_o = term_q;
  assign run_last_o      = last_q;

endmodule

/* rtl/core/escape_sequence_decoder.sv */
// Escape sequence decoder: takes one text byte per word and gives the decoded
// bytes of C-style backslash escapes, marking the last result of each input
// word and closing each text with a terminator word. An input word is taken
// every cycle while the two-entry burst queue has room; a word that causes
// one result keeps a sustained rate of one word per cycle while the output is
// ready. A word that causes several results (up to four, for a malformed \x or
// an end of text) is sent out one result per cycle by the back end while the
// output is ready, so the rate over a stretch is set by the output side at one
// result per cycle, and input stalls once the queue fills. An accepted word's
// first result goes via a queue entry and the output register. Backslashes and
// first hex digits of \x cause no result and never reach the queue.
// Depends on esd_pkg, esd_front, esd_queue and esd_back.
module escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_terminator_o,
  output logic       run_last_o
);
  import esd_pkg::*;

  burst_t push_burst, head_burst;
  logic   push, pop, full, head_valid;

  // Classify input words
  esd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_burst_o     (push_burst)
  );

  // Buffer bursts
  esd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .burst_i (push_burst),
    .full_o  (full),
    .pop_i   (pop),
    .burst_o (head_burst),
    .valid_o (head_valid)
  );

  // Send results
  esd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (head_valid),
    .q_burst_i       (head_burst),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_terminator_o (is_terminator_o),
    .run_last_o      (run_last_o)
  );

endmodule
